// ===== hw/rtl/srr_pkg.sv =====
// srr_pkg: shared types and constants of the selective repeat receiver
// used by srr_regs, srr_ctrl, srr_datapath and selective_repeat_receiver
// depends on nothing
`default_nettype none

package srr_pkg;

    // sequence number width and receive bitmap capacity (power of two)
    localparam int SEQ_W      = 16;
    localparam int WINDOW_MAX = 16;
    localparam int SLOT_W     = $clog2(WINDOW_MAX);

    // register field widths
    localparam int WIN_W  = 5;
    localparam int CNT_W  = 5;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    // register reset values
    localparam logic [WIN_W-1:0] WIN_RESET   = WIN_W'(4);
    localparam logic [SEQ_W-1:0] TOTAL_RESET = SEQ_W'(10);

    // register indexes, taken from paddr[2]
    typedef enum logic {
        REG_WINDOW_SIZE  = 1'b0,
        REG_TOTAL_FRAMES = 1'b1
    } t_reg_idx;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MARK,
        ST_WALK
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic mark;
        logic step;
        logic emit;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic walk_more;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ===== hw/rtl/srr_regs.sv =====
// srr_regs: configuration registers behind an APB-style port
// holds window_size and total_frames; depends on srr_pkg
`default_nettype none

module srr_regs (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [srr_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [srr_pkg::DATA_W-1:0]   pwdata,
    output logic      [srr_pkg::DATA_W-1:0]   prdata,
    output logic                              pready,
    output logic      [srr_pkg::WIN_W-1:0]    o_window_size,
    output logic      [srr_pkg::SEQ_W-1:0]    o_total_frames
);
    import srr_pkg::*;

    logic              wr_en;
    t_reg_idx          reg_idx;
    logic [WIN_W-1:0]  r_window_size;
    logic [SEQ_W-1:0]  r_total_frames;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = t_reg_idx'(paddr[2]);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size  <= WIN_RESET;
            r_total_frames <= TOTAL_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_WINDOW_SIZE:  r_window_size  <= pwdata[WIN_W-1:0];
                REG_TOTAL_FRAMES: r_total_frames <= pwdata[SEQ_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_WINDOW_SIZE:  prdata = DATA_W'(r_window_size);
            REG_TOTAL_FRAMES: prdata = DATA_W'(r_total_frames);
            default:          prdata = '0;
        endcase
    end

    assign o_window_size  = r_window_size;
    assign o_total_frames = r_total_frames;

endmodule

`default_nettype wire

// ===== hw/rtl/srr_ctrl.sv =====
// srr_ctrl: sequencer of the receiver, one request at a time
// issues load, mark, walk steps and result emit; depends on srr_pkg
`default_nettype none

module srr_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire srr_pkg::t_status i_status,
    output srr_pkg::t_cmd         o_cmd
);
    import srr_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_MARK;
            end
            ST_MARK: n_state = ST_WALK;
            ST_WALK: begin
                if (!i_status.walk_more && i_status.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_MARK: o_cmd.mark = 1'b1;
            ST_WALK: begin
                o_cmd.step = i_status.walk_more;
                o_cmd.emit = !i_status.walk_more && i_status.out_free;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/srr_datapath.sv =====
// srr_datapath: window base, receive bitmap, walk counter and result register
// driven by srr_ctrl commands; depends on srr_pkg
`default_nettype none

module srr_datapath (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire srr_pkg::t_cmd               i_cmd,
    output srr_pkg::t_status                 o_status,
    input  wire logic [srr_pkg::SEQ_W-1:0]   i_frame_number,
    input  wire logic [srr_pkg::WIN_W-1:0]   i_window_size,
    input  wire logic [srr_pkg::SEQ_W-1:0]   i_total_frames,
    input  wire logic                        i_out_ready,
    output logic                             o_out_valid,
    output logic      [srr_pkg::SEQ_W-1:0]   o_ack_number,
    output logic                             o_buffered,
    output logic      [srr_pkg::CNT_W-1:0]   o_delivered_count,
    output logic      [srr_pkg::SEQ_W-1:0]   o_next_expected,
    output logic                             o_done_res
);
    import srr_pkg::*;

    localparam logic [WIN_W-1:0] WIN_CAP = WIN_W'(WINDOW_MAX);

    // control state
    logic [SEQ_W-1:0]      r_base;
    logic [WINDOW_MAX-1:0] r_map;
    logic                  r_out_valid;

    // payload
    logic [SEQ_W-1:0]      r_frame;
    logic                  r_buffered;
    logic [CNT_W-1:0]      r_count;
    logic [SEQ_W-1:0]      r_ack;
    logic                  r_out_buffered;
    logic [CNT_W-1:0]      r_out_count;
    logic [SEQ_W-1:0]      r_out_next;
    logic                  r_out_done;

    logic [WIN_W-1:0]      win;
    logic [SEQ_W:0]        win_end;
    logic                  active;
    logic                  in_window;
    logic [SLOT_W-1:0]     frame_slot;
    logic [SLOT_W-1:0]     base_slot;

    // window limit and acceptance test
    assign win        = (i_window_size > WIN_CAP) ? WIN_CAP : i_window_size;
    assign win_end    = {1'b0, r_base} + (SEQ_W + 1)'(win);
    assign active     = r_base < i_total_frames;
    assign in_window  = active && (r_frame >= r_base) && ({1'b0, r_frame} < win_end) &&
                        (r_frame < i_total_frames);
    assign frame_slot = r_frame[SLOT_W-1:0];
    assign base_slot  = r_base[SLOT_W-1:0];

    assign o_status.walk_more = active && r_map[base_slot];
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    // base, bitmap and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_map       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.mark && in_window) r_map[frame_slot] <= 1'b1;
            if (i_cmd.step) begin
                r_map[base_slot] <= 1'b0;
                r_base           <= r_base + SEQ_W'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // per-request working values and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_frame    <= i_frame_number;
            r_buffered <= 1'b0;
            r_count    <= '0;
        end
        if (i_cmd.mark) r_buffered <= in_window;
        if (i_cmd.step) r_count <= r_count + CNT_W'(1);
        if (i_cmd.emit) begin
            r_ack          <= r_frame;
            r_out_buffered <= r_buffered;
            r_out_count    <= r_count;
            r_out_next     <= r_base;
            r_out_done     <= !active;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_ack_number      = r_ack;
    assign o_buffered        = r_out_buffered;
    assign o_delivered_count = r_out_count;
    assign o_next_expected   = r_out_next;
    assign o_done_res        = r_out_done;

endmodule

`default_nettype wire

// ===== hw/rtl/selective_repeat_receiver.sv =====
// selective_repeat_receiver: top level of the selective repeat ARQ receiver
// instantiates srr_regs, srr_ctrl and srr_datapath; depends on srr_pkg
//
// usage:
//   input channel (i_in_valid / o_in_ready) carries one received frame number
//   per request; output channel (o_out_valid / i_out_ready) returns one result
//   per request: the acknowledged number, whether it was buffered, how many
//   frames were delivered in order, the new window base and the done flag.
//   window_size (address 0) and total_frames (address 4) are written over the
//   APB-style port while the block is idle; pready is always high.
// timing:
//   one request at a time; a request runs through accept, mark and a delivery
//   walk that checks one bitmap slot per cycle and delivers n (0 to 16) frames;
//   the result register is loaded when the walk ends and the output is free.
// reset:
//   synchronous, clears the window base, the receive bitmap and the result
//   valid; registers return to window_size 4 and total_frames 10.
// stall:
//   a result waits in its output register; the next request is still taken
//   and worked on, and its walk holds at the end until the register frees.
`default_nettype none

module selective_repeat_receiver (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [srr_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [srr_pkg::DATA_W-1:0]  pwdata,
    output logic      [srr_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    // input channel
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [srr_pkg::SEQ_W-1:0]   i_frame_number,
    // output channel
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic      [srr_pkg::SEQ_W-1:0]   o_ack_number,
    output logic                             o_buffered,
    output logic      [srr_pkg::CNT_W-1:0]   o_delivered_count,
    output logic      [srr_pkg::SEQ_W-1:0]   o_next_expected,
    output logic                             o_done_res
);
    import srr_pkg::*;

    logic [WIN_W-1:0] window_size;
    logic [SEQ_W-1:0] total_frames;
    t_cmd             cmd;
    t_status          status;

    // configuration registers
    srr_regs u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_window_size  (window_size),
        .o_total_frames (total_frames)
    );

    // sequencer
    srr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // window state and result register
    srr_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_frame_number    (i_frame_number),
        .i_window_size     (window_size),
        .i_total_frames    (total_frames),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_ack_number      (o_ack_number),
        .o_buffered        (o_buffered),
        .o_delivered_count (o_delivered_count),
        .o_next_expected   (o_next_expected),
        .o_done_res        (o_done_res)
    );

endmodule

`default_nettype wire

// ===== tb/selective_repeat_receiver_test.sv =====
`timescale 1ns / 100ps
// selective_repeat_receiver_test: self-checking bench for the selective repeat receiver
// runs a directed table, then random frame bursts under varying window and total settings
// depends on srr_pkg and selective_repeat_receiver
`default_nettype none

module selective_repeat_receiver_test;
    import srr_pkg::*;

    localparam int     N_PHASES        = 25;
    localparam int     ITEMS_PER_PHASE = 80;
    localparam int     N_ROWS          = 26;
    localparam longint LIMIT_NS        = 5_000_000;

    // one acknowledgment as seen on the output channel
    typedef struct packed {
        logic [SEQ_W-1:0] ack;
        logic             buffered;
        logic [CNT_W-1:0] delivered;
        logic [SEQ_W-1:0] next_base;
        logic             done;
    } t_receipt;

    // directed table: a frame request or a register write, with an optional typed answer
    typedef enum logic {
        ROW_FRAME,
        ROW_WRITE
    } t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        t_reg_idx         reg_idx;
        logic [SEQ_W-1:0] value;
        logic             typed;
        logic             buffered;
        logic [CNT_W-1:0] delivered;
        logic [SEQ_W-1:0] next_base;
        logic             done;
    } t_row;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               psel           = 1'b0;
    logic               penable        = 1'b0;
    logic               pwrite         = 1'b0;
    logic [ADDR_W-1:0]  paddr          = '0;
    logic [DATA_W-1:0]  pwdata         = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               i_in_valid     = 1'b0;
    logic               o_in_ready;
    logic [SEQ_W-1:0]   i_frame_number = '0;
    logic               o_out_valid;
    logic               i_out_ready    = 1'b0;
    logic [SEQ_W-1:0]   o_ack_number;
    logic               o_buffered;
    logic [CNT_W-1:0]   o_delivered_count;
    logic [SEQ_W-1:0]   o_next_expected;
    logic               o_done_res;

    // receiver state as predicted by the bench
    logic [WIN_W-1:0]      win_cfg;
    logic [SEQ_W-1:0]      total_cfg;
    logic [SEQ_W-1:0]      base_model;
    logic [WINDOW_MAX-1:0] held_frames;
    t_receipt              pending_acks [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int n_errors       = 0;
    int n_requests     = 0;
    int n_writes       = 0;
    int n_buffered     = 0;
    int n_multi_walks  = 0;
    int n_full_walks   = 0;
    int n_done_acks    = 0;

    t_row directed_rows [N_ROWS] = '{
        '{ROW_FRAME, REG_WINDOW_SIZE,  16'd0,     1'b1, 1'b1, 5'd1, 16'd1, 1'b0},
        '{ROW_FRAME, REG_WINDOW_SIZE,  16'd2,     1'b1, 1'b1, 5'd0, 16'd1, 1'b0},
        '{ROW_FRAME, REG_WINDOW_SIZE,  16'd4,     1'b1, 1'b1, 5'd0, 16'd1, 1'b0},
        '{ROW_FRAME, REG_WINDOW_SIZE,  16'd5,     1'b1, 1'b0, 5'd0, 16'd1, 1'b0},
        '{ROW_FRAME, REG_WINDOW_SIZE,  16'd0,     1'b1, 1'b0, 5'd0, 16'd1, 1'b0},
        '{ROW_FRAME, REG_WINDOW_SIZE,  16'd2,     1'b1, 1'b1, 5'd0, 16'd1, 1'b0},
        '{ROW_FRAME, REG_WINDOW_SIZE,  16'd1,     1'b0, 1'b0, 5'd0, 16'd0, 1'b0},
        '{ROW_FRAME, REG_WINDOW_SIZE,  16'd65535, 1'b1, 1'b0, 5'd0, 16'd3, 1'b0},
        '{ROW_WRITE, REG_WINDOW_SIZE,  16'd0,     1'b0, 1'b0, 5'd0, 16'd0, 1'b0},
        '{ROW_FRAME, REG_WINDOW_SIZE,  16'd3,     1'b1, 1'b0, 5'd0, 16'd3, 1'b0},
        '{ROW_WRITE, REG_WINDOW_SIZE,  16'd31,    1'b0, 1'b0, 5'd0, 16'd0, 1'b0},
        '{ROW_FRAME, REG_WINDOW_SIZE,  16'd9,     1'b0, 1'b0, 5'd0, 16'd0, 1'b0},
        '{ROW_FRAME, REG_WINDOW_SIZE,  16'd10,    1'b0, 1'b0, 5'd0, 16'd0, 1'b0},
        '{ROW_WRITE, REG_TOTAL_FRAMES, 16'd0,     1'b0, 1'b0, 5'd0, 16'd0, 1'b0},
        '{ROW_FRAME, REG_WINDOW_SIZE,  16'd3,     1'b1, 1'b0, 5'd0, 16'd3, 1'b1},
        '{ROW_WRITE, REG_TOTAL_FRAMES, 16'd65535, 1'b0, 1'b0, 5'd0, 16'd0, 1'b0},
        '{ROW_FRAME, REG_WINDOW_SIZE,  16'd3,     1'b0, 1'b0, 5'd0, 16'd0, 1'b0},
        '{ROW_WRITE, REG_WINDOW_SIZE,  16'd16,    1'b0, 1'b0, 5'd0, 16'd0, 1'b0},
        '{ROW_FRAME, REG_WINDOW_SIZE,  16'd20,    1'b0, 1'b0, 5'd0, 16'd0, 1'b0},
        '{ROW_FRAME, REG_WINDOW_SIZE,  16'd21,    1'b0, 1'b0, 5'd0, 16'd0, 1'b0},
        '{ROW_FRAME, REG_WINDOW_SIZE,  16'd5,     1'b0, 1'b0, 5'd0, 16'd0, 1'b0},
        '{ROW_WRITE, REG_TOTAL_FRAMES, 16'd6,     1'b0, 1'b0, 5'd0, 16'd0, 1'b0},
        '{ROW_FRAME, REG_WINDOW_SIZE,  16'd12,    1'b1, 1'b0, 5'd0, 16'd6, 1'b1},
        '{ROW_WRITE, REG_WINDOW_SIZE,  16'd1,     1'b0, 1'b0, 5'd0, 16'd0, 1'b0},
        '{ROW_WRITE, REG_TOTAL_FRAMES, 16'd7,     1'b0, 1'b0, 5'd0, 16'd0, 1'b0},
        '{ROW_FRAME, REG_WINDOW_SIZE,  16'd6,     1'b0, 1'b0, 5'd0, 16'd0, 1'b0}
    };

    selective_repeat_receiver DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_frame_number    (i_frame_number),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_ack_number      (o_ack_number),
        .o_buffered        (o_buffered),
        .o_delivered_count (o_delivered_count),
        .o_next_expected   (o_next_expected),
        .o_done_res        (o_done_res)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mark the frame if it falls in the window, then walk the base over marked slots
    function automatic t_receipt accept_frame(input logic [SEQ_W-1:0] frame);
        t_receipt    r;
        int unsigned span;
        r     = '0;
        r.ack = frame;
        span  = (win_cfg > WINDOW_MAX) ? WINDOW_MAX : win_cfg;
        if (base_model < total_cfg) begin
            if (frame >= base_model && frame < base_model + span && frame < total_cfg) begin
                held_frames[frame % WINDOW_MAX] = 1'b1;
                r.buffered = 1'b1;
            end
            while (base_model < total_cfg && held_frames[base_model % WINDOW_MAX]) begin
                held_frames[base_model % WINDOW_MAX] = 1'b0;
                base_model  = base_model + 1'b1;
                r.delivered = r.delivered + 1'b1;
            end
        end
        r.next_base = base_model;
        r.done      = (base_model >= total_cfg);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        n_errors++;
        if (n_errors <= 50)
            $display("%0t ns: %s mismatch, got %0h want %0h", $time, what, got, want);
    endtask

    // present one request, hold it until taken, then queue its expected ack
    task automatic send_frame(input logic [SEQ_W-1:0] frame, input logic typed,
                              input t_receipt want);
        t_receipt r;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < send_idle_pct) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_frame_number <= frame;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        r = accept_frame(frame);
        pending_acks.push_back(typed ? want : r);
        n_requests++;
    endtask

    // stop sending and wait for every outstanding ack
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_acks.size() != 0) @(posedge i_clk);
    endtask

    // apb write with junk above the field, then read it back
    task automatic write_reg(input t_reg_idx idx, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] field;
        drain_results();
        mask  = (idx == REG_WINDOW_SIZE) ? DATA_W'((1 << WIN_W) - 1) : DATA_W'((1 << SEQ_W) - 1);
        field = value & mask;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << 2;
        pwdata  <= ($urandom() & ~mask) | field;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == REG_WINDOW_SIZE)
            win_cfg = field[WIN_W-1:0];
        else
            total_cfg = field[SEQ_W-1:0];
        n_writes++;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== field) report_mismatch("register readback", prdata, field);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // compare each ack against the oldest expectation
    always @(posedge i_clk) begin : check_acks
        t_receipt want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_acks.size() == 0) begin
                report_mismatch("ack with no request", o_ack_number, 0);
            end else begin
                want = pending_acks.pop_front();
                if (o_ack_number !== want.ack)
                    report_mismatch("ack_number", o_ack_number, want.ack);
                if (o_buffered !== want.buffered)
                    report_mismatch("buffered", o_buffered, want.buffered);
                if (o_delivered_count !== want.delivered)
                    report_mismatch("delivered_count", o_delivered_count, want.delivered);
                if (o_next_expected !== want.next_base)
                    report_mismatch("next_expected", o_next_expected, want.next_base);
                if (o_done_res !== want.done)
                    report_mismatch("done_res", o_done_res, want.done);
                n_buffered += want.buffered;
                if (want.delivered > 1) n_multi_walks++;
                if (want.delivered == WINDOW_MAX) n_full_walks++;
                if (want.done) n_done_acks++;
            end
        end
    end

    initial begin : stimulus
        t_row          row;
        t_receipt      want;
        int unsigned   span;
        int unsigned   burst_base;
        int unsigned   win_pick;
        int unsigned   total_pick;
        int unsigned   noise;
        int unsigned   j;
        int unsigned   tmp;
        int            n_phase_items;
        int unsigned   offsets [$];

        win_cfg     = WIN_RESET;
        total_cfg   = TOTAL_RESET;
        base_model  = '0;
        held_frames = '0;

        // reset, then the directed table with sender idling 27 and receiver 70
        send_idle_pct  = 27;
        recv_stall_pct = 70;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < N_ROWS; k++) begin
            row = directed_rows[k];
            if (row.kind == ROW_WRITE) begin
                write_reg(row.reg_idx, DATA_W'(row.value));
            end else begin
                want.ack       = row.value;
                want.buffered  = row.buffered;
                want.delivered = row.delivered;
                want.next_base = row.next_base;
                want.done      = row.done;
                send_frame(row.value, row.typed, want);
            end
        end

        // random phases, each under its own window and transfer length
        for (int p = 0; p < N_PHASES; p++) begin
            case (p * 3 / N_PHASES)
                0: begin
                    send_idle_pct  = 27;
                    recv_stall_pct = 70;
                end
                1: begin
                    send_idle_pct  = 70;
                    recv_stall_pct = 27;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase

            if (p == 0) begin
                win_pick   = 16;
                total_pick = 65535;
            end else if (p == 1) begin
                win_pick   = 1;
                total_pick = 65535;
            end else if (p == 2) begin
                win_pick   = 31;
                total_pick = 1;
            end else begin
                case ($urandom_range(0, 9))
                    0:       win_pick = 0;
                    1:       win_pick = $urandom_range(17, 31);
                    2:       win_pick = 16;
                    3:       win_pick = 1;
                    default: win_pick = $urandom_range(2, 15);
                endcase
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: total_pick = 65535;
                    5, 6: begin
                        total_pick = base_model + $urandom_range(1, 40);
                        if (total_pick > 65535) total_pick = 65535;
                    end
                    7:       total_pick = $urandom_range(0, base_model);
                    8:       total_pick = $urandom_range(0, 1);
                    default: total_pick = $urandom_range(0, 65535);
                endcase
            end
            write_reg(REG_WINDOW_SIZE, DATA_W'(win_pick));
            write_reg(REG_TOTAL_FRAMES, DATA_W'(total_pick));

            n_phase_items = 0;
            while (n_phase_items < ITEMS_PER_PHASE) begin
                span = (win_cfg > WINDOW_MAX) ? WINDOW_MAX : win_cfg;
                if (span == 0) span = 4;
                if ($urandom_range(0, 99) < 80) begin
                    // current window out of order, a few frames lost, a few repeated
                    burst_base = base_model;
                    offsets.delete();
                    for (int i = 0; i < span; i++)
                        if ($urandom_range(0, 99) >= 8) offsets.push_back(i);
                    repeat ($urandom_range(0, 2)) offsets.push_back($urandom_range(0, span + 1));
                    for (int i = offsets.size() - 1; i > 0; i--) begin
                        j          = $urandom_range(0, i);
                        tmp        = offsets[i];
                        offsets[i] = offsets[j];
                        offsets[j] = tmp;
                    end
                    foreach (offsets[i]) begin
                        send_frame(SEQ_W'(burst_base + offsets[i]), 1'b0, '0);
                        n_phase_items++;
                    end
                end else begin
                    // stray frame: anywhere, already delivered, past the window or the end
                    case ($urandom_range(0, 3))
                        0:       noise = $urandom_range(0, 65535);
                        1:       noise = base_model - 1 - $urandom_range(0, 20);
                        2:       noise = base_model + span + $urandom_range(0, 20);
                        default: noise = total_cfg + $urandom_range(0, 3);
                    endcase
                    send_frame(SEQ_W'(noise), 1'b0, '0);
                    n_phase_items++;
                end
            end
        end

        drain_results();
        repeat (40) @(posedge i_clk);
        $display("run: %0d frame requests, %0d register writes, %0d frames buffered",
                 n_requests, n_writes, n_buffered);
        $display("run: %0d multi-frame deliveries, %0d full-window deliveries, %0d acks after done",
                 n_multi_walks, n_full_walks, n_done_acks);
        if (n_errors == 0 && pending_acks.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // hang guard
    initial begin : watchdog
        #(LIMIT_NS);
        $display("timeout with %0d acks outstanding", pending_acks.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire

// ===== selective_repeat_receiver.f =====
hw/rtl/srr_pkg.sv
hw/rtl/srr_regs.sv
hw/rtl/srr_ctrl.sv
hw/rtl/srr_datapath.sv
hw/rtl/selective_repeat_receiver.sv
tb/selective_repeat_receiver_test.sv
